// ----- rtl/stkr_pkg.sv -----
// Shared types, constants and the key permutation for the touch keypad reader.
// Used by every module under rtl; has no dependencies of its own.
package stkr_pkg;

  localparam int unsigned KEY_COUNT  = 16;
  localparam int unsigned FRAME_BITS = 17;
  localparam int unsigned WORD_BITS  = 16;
  localparam int unsigned TICK_BITS  = 32;
  localparam int unsigned BIT_CNT_BITS = 5;

  localparam logic [2:0] CAL_DISCARDS = 3'd4;
  localparam logic [2:0] CAL_LAST     = 3'd5;

  localparam logic [15:0] HALF_PERIOD_RESET   = 16'd720;
  localparam logic [15:0] VALID_TIMEOUT_RESET = 16'd5000;
  localparam logic [31:0] SETTLE_RESET        = 32'd2880000;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_HIGH   = 3'd2,
    PH_LOW    = 3'd3,
    PH_SETTLE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CALIB = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    REG_HALF_PERIOD   = 2'd0,
    REG_VALID_TIMEOUT = 2'd1,
    REG_SETTLE        = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] valid_timeout_ticks;
    logic [31:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic        clock_line;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] key_map;
    logic [15:0] raw_word;
  } res_t;

  localparam logic [3:0] KEY_SRC [16] = '{
    4'd6, 4'd4, 4'd7, 4'd5, 4'd2, 4'd12, 4'd13, 4'd14,
    4'd15, 4'd0, 4'd1, 4'd8, 4'd9, 4'd10, 4'd11, 4'd3
  };

  // Touched keys read low, so the raw word is inverted before the baseline mask.
  function automatic logic [15:0] permute_keys(logic [15:0] raw, logic [15:0] base);
    logic [15:0] masked;
    logic [15:0] map;
    masked = (~raw) & base;
    map = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < int'(KEY_COUNT)) map[i] = masked[KEY_SRC[i]];
    end
    return map;
  endfunction

endpackage

// ----- rtl/stkr_cfg.sv -----
// Configuration register file of the touch keypad reader.
// Depends on stkr_pkg for the register indexes and the configuration struct.
module stkr_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  output stkr_pkg::cfg_t     cfg
);

  stkr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks   <= stkr_pkg::HALF_PERIOD_RESET;
      cfg_r.valid_timeout_ticks <= stkr_pkg::VALID_TIMEOUT_RESET;
      cfg_r.settle_ticks        <= stkr_pkg::SETTLE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        stkr_pkg::REG_HALF_PERIOD:   cfg_r.half_period_ticks   <= wr_data[15:0];
        stkr_pkg::REG_VALID_TIMEOUT: cfg_r.valid_timeout_ticks <= wr_data[15:0];
        stkr_pkg::REG_SETTLE:        cfg_r.settle_ticks        <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/stkr_core.sv -----
// Sequencer state and per-tick step logic of the touch keypad reader.
// Depends on stkr_pkg for phases, commands, structs and the key permutation.
module stkr_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic [1:0]     func,
  input  logic           data_line,
  input  stkr_pkg::cfg_t cfg,
  output stkr_pkg::res_t res
);

  stkr_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [4:0]  bit_cnt_r, bit_cnt_nxt;
  logic [16:0] shift_r, shift_nxt;
  logic [15:0] cached_r, cached_nxt;
  logic [15:0] base_r, base_nxt;
  logic [15:0] interim_r, interim_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        cal_r, cal_nxt;

  logic [31:0] hp, vt, st, tick_inc;
  logic        fin, fell_back, done;
  logic [15:0] fin_word;

  // A register holding zero behaves as one.
  assign hp = (cfg.half_period_ticks == 16'd0) ? 32'd1 : {16'd0, cfg.half_period_ticks};
  assign vt = (cfg.valid_timeout_ticks == 16'd0) ? 32'd1 : {16'd0, cfg.valid_timeout_ticks};
  assign st = (cfg.settle_ticks == 32'd0) ? 32'd1 : cfg.settle_ticks;
  assign tick_inc = tick_r + 32'd1;

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    cached_nxt  = cached_r;
    base_nxt    = base_r;
    interim_nxt = interim_r;
    step_nxt    = step_r;
    cal_nxt     = cal_r;
    fin         = 1'b0;
    fell_back   = 1'b0;
    fin_word    = shift_r[15:0];
    done        = 1'b0;

    case (phase_r)
      stkr_pkg::PH_IDLE: begin
        if (func == stkr_pkg::FUNC_READ || func == stkr_pkg::FUNC_CALIB) begin
          cal_nxt   = (func == stkr_pkg::FUNC_CALIB);
          step_nxt  = 3'd0;
          tick_nxt  = '0;
          phase_nxt = stkr_pkg::PH_WAIT;
        end
      end
      stkr_pkg::PH_WAIT: begin
        if (data_line) begin
          phase_nxt   = stkr_pkg::PH_HIGH;
          tick_nxt    = '0;
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
        end else begin
          tick_nxt = tick_inc;
          if (tick_inc >= vt) begin
            fin       = 1'b1;
            fell_back = 1'b1;
            if (!cal_r)                          fin_word = cached_r;
            else if (step_r >= stkr_pkg::CAL_LAST) fin_word = interim_r;
            else                                 fin_word = 16'hFFFF;
          end
        end
      end
      stkr_pkg::PH_HIGH: begin
        tick_nxt = tick_inc;
        if (tick_inc >= hp) begin
          shift_nxt = {shift_r[15:0], data_line};
          tick_nxt  = '0;
          phase_nxt = stkr_pkg::PH_LOW;
        end
      end
      stkr_pkg::PH_LOW: begin
        tick_nxt = tick_inc;
        if (tick_inc >= hp) begin
          tick_nxt    = '0;
          bit_cnt_nxt = bit_cnt_r + 5'd1;
          if (bit_cnt_nxt >= 5'(stkr_pkg::FRAME_BITS)) begin
            fin      = 1'b1;
            fin_word = shift_r[15:0];
          end else begin
            phase_nxt = stkr_pkg::PH_HIGH;
          end
        end
      end
      stkr_pkg::PH_SETTLE: begin
        tick_nxt = tick_inc;
        if (tick_inc >= st) begin
          tick_nxt  = '0;
          phase_nxt = stkr_pkg::PH_WAIT;
        end
      end
      default: phase_nxt = stkr_pkg::PH_IDLE;
    endcase

    // End of one transfer: a plain read or the last calibration read ends the
    // sequence, any earlier calibration read pauses before the next one.
    if (fin) begin
      if (!cal_r) begin
        cached_nxt = fin_word;
        phase_nxt  = stkr_pkg::PH_IDLE;
        done       = 1'b1;
      end else if (step_r >= stkr_pkg::CAL_LAST) begin
        cached_nxt = fin_word;
        base_nxt   = fin_word;
        cal_nxt    = 1'b0;
        step_nxt   = 3'd0;
        phase_nxt  = stkr_pkg::PH_IDLE;
        done       = 1'b1;
      end else begin
        if (step_r == stkr_pkg::CAL_DISCARDS) interim_nxt = fin_word;
        step_nxt  = step_r + 3'd1;
        phase_nxt = stkr_pkg::PH_SETTLE;
        tick_nxt  = '0;
      end
    end

    res.clock_line = (phase_r == stkr_pkg::PH_HIGH);
    res.busy_res   = (phase_r != stkr_pkg::PH_IDLE);
    res.done_res   = done;
    res.timed_out  = done && fell_back;
    res.key_map    = done ? stkr_pkg::permute_keys(cached_nxt, base_nxt) : 16'd0;
    res.raw_word   = cached_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= stkr_pkg::PH_IDLE;
      tick_r    <= '0;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      cached_r  <= 16'hFFFF;
      base_r    <= 16'hFFFF;
      interim_r <= 16'hFFFF;
      step_r    <= '0;
      cal_r     <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      cached_r  <= cached_nxt;
      base_r    <= base_nxt;
      interim_r <= interim_nxt;
      step_r    <= step_nxt;
      cal_r     <= cal_nxt;
    end
  end

endmodule

// ----- rtl/serial_touch_keypad_reader.sv -----
// Two-wire touch keypad reader: one input item per system tick, one result per item.
// The result of an accepted item is in the output register in the next cycle.
// Throughput is one item per cycle, set by the single sequencer step between the state
// registers and the output register; input is taken while that register is empty or drains.
// Synchronous active-low reset returns the sequencer to idle, sets cached and baseline
// words to all ones and loads default timing. Depends on stkr_pkg, stkr_cfg and stkr_core.
module serial_touch_keypad_reader (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] data_line, [7:1] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] clock_line, [1] busy_res, [2] done_res,
                                  // [3] timed_out, [19:4] key_map, [35:20] raw_word,
                                  // [39:36] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  stkr_pkg::cfg_t cfg;
  stkr_pkg::res_t res;
  stkr_pkg::res_t out_r;
  logic           out_valid_r;
  logic           in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  stkr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  stkr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_fire),
    .func      (in_tuser),
    .data_line (in_tdata[0]),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.raw_word, out_r.key_map, out_r.timed_out,
                       out_r.done_res, out_r.busy_res, out_r.clock_line};

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the serial touch keypad reader: each input item is one tick,
// and every result item is checked against an in-bench model of the read sequencer.
// Depends on stkr_pkg and the serial_touch_keypad_reader RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stkr_pkg::*;

  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned LONG_HOLD    = 250;
  localparam int unsigned PRINT_MAX    = 100;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;

  // Key i of the map is taken from raw bit KEY_WIRE[4*i +: 4].
  localparam logic [63:0] KEY_WIRE = {4'd3, 4'd11, 4'd10, 4'd9, 4'd8, 4'd1, 4'd0, 4'd15,
                                      4'd14, 4'd13, 4'd12, 4'd2, 4'd5, 4'd7, 4'd4, 4'd6};

  typedef struct packed {
    logic [1:0] func;
    logic       data;
  } tick_item_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic [1:0]  in_tuser   = FUNC_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = REG_HALF_PERIOD;
  logic [31:0] cfg_data   = 32'd0;

  serial_touch_keypad_reader dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Model of the sequencer and its registers.
  logic [15:0] kp_half    = HALF_PERIOD_RESET;
  logic [15:0] kp_timeout = VALID_TIMEOUT_RESET;
  logic [31:0] kp_settle  = SETTLE_RESET;
  phase_t      kp_phase   = PH_IDLE;
  logic [31:0] kp_ticks   = 32'd0;
  logic [4:0]  kp_bits    = 5'd0;
  logic [16:0] kp_shift   = 17'd0;
  logic [15:0] kp_cached  = 16'hFFFF;
  logic [15:0] kp_base    = 16'hFFFF;
  logic [15:0] kp_interim = 16'hFFFF;
  logic [2:0]  kp_step    = 3'd0;
  logic        kp_calib   = 1'b0;

  tick_item_t  tick_q[$];
  res_t        frame_result_q[$];

  int unsigned err_cnt   = 0;
  int unsigned seen_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int          tx_gap    = 0;
  int          tx_burst  = 1;
  int          hold_left = 0;
  int          rx_slot   = 0;
  logic [31:0] rx_mask   = 32'hFFFFFFFF;
  bit          hold_req  = 1'b0;
  bit          no_calib_start = 1'b0;
  tick_item_t  cur_tick;
  res_t        pred_res;
  res_t        want_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (err_cnt < PRINT_MAX)
      $display("[%0t] result %0d: %s got %h want %h", $realtime, seen_cnt, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [31:0] eff_half();
    return (kp_half == 16'd0) ? 32'd1 : {16'd0, kp_half};
  endfunction

  function automatic logic [31:0] eff_timeout();
    return (kp_timeout == 16'd0) ? 32'd1 : {16'd0, kp_timeout};
  endfunction

  function automatic logic [31:0] eff_settle();
    return (kp_settle == 32'd0) ? 32'd1 : kp_settle;
  endfunction

  // Ends one transfer; a calibration moves on to its settle pause until the last read.
  task automatic end_transfer(input logic [15:0] word, output logic fin);
    fin = 1'b0;
    if (!kp_calib) begin
      kp_cached = word;
      kp_phase  = PH_IDLE;
      fin       = 1'b1;
    end else if (kp_step >= CAL_LAST) begin
      kp_cached = word;
      kp_base   = word;
      kp_calib  = 1'b0;
      kp_step   = 3'd0;
      kp_phase  = PH_IDLE;
      fin       = 1'b1;
    end else begin
      if (kp_step == CAL_DISCARDS) kp_interim = word;
      kp_step  = kp_step + 3'd1;
      kp_phase = PH_SETTLE;
      kp_ticks = 32'd0;
    end
  endtask

  task automatic keypad_tick(input logic [1:0] func, input logic data, output res_t r);
    logic        fin;
    logic        fell;
    logic [15:0] fallback;
    logic [15:0] masked;
    r = '0;
    r.clock_line = (kp_phase == PH_HIGH);
    r.busy_res   = (kp_phase != PH_IDLE);
    fin  = 1'b0;
    fell = 1'b0;
    case (kp_phase)
      PH_IDLE: begin
        if (func == FUNC_READ || func == FUNC_CALIB) begin
          kp_calib = (func == FUNC_CALIB);
          kp_step  = 3'd0;
          kp_ticks = 32'd0;
          kp_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (data) begin
          kp_phase = PH_HIGH;
          kp_ticks = 32'd0;
          kp_bits  = 5'd0;
          kp_shift = 17'd0;
        end else begin
          kp_ticks = kp_ticks + 32'd1;
          if (kp_ticks >= eff_timeout()) begin
            fell = 1'b1;
            if (!kp_calib) fallback = kp_cached;
            else fallback = (kp_step >= CAL_LAST) ? kp_interim : 16'hFFFF;
            end_transfer(fallback, fin);
          end
        end
      end
      PH_HIGH: begin
        kp_ticks = kp_ticks + 32'd1;
        if (kp_ticks >= eff_half()) begin
          kp_shift = {kp_shift[15:0], data};
          kp_ticks = 32'd0;
          kp_phase = PH_LOW;
        end
      end
      PH_LOW: begin
        kp_ticks = kp_ticks + 32'd1;
        if (kp_ticks >= eff_half()) begin
          kp_ticks = 32'd0;
          kp_bits  = kp_bits + 5'd1;
          if (kp_bits >= 5'(FRAME_BITS)) end_transfer(kp_shift[15:0], fin);
          else kp_phase = PH_HIGH;
        end
      end
      PH_SETTLE: begin
        kp_ticks = kp_ticks + 32'd1;
        if (kp_ticks >= eff_settle()) begin
          kp_ticks = 32'd0;
          kp_phase = PH_WAIT;
        end
      end
      default: kp_phase = PH_IDLE;
    endcase
    r.done_res  = fin;
    r.timed_out = fin & fell;
    if (fin) begin
      masked = ~kp_cached & kp_base;
      for (int i = 0; i < int'(KEY_COUNT); i++) r.key_map[i] = masked[KEY_WIRE[4*i +: 4]];
    end
    r.raw_word = kp_cached;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        keypad_tick(in_tuser, in_tdata[0], pred_res);
        frame_result_q.push_back(pred_res);
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          cur_tick = tick_q.pop_front();
          in_tuser  <= cur_tick.func;
          in_tdata  <= {7'd0, cur_tick.data};
          in_tvalid <= 1'b1;
          if (tx_burst <= 1) begin
            tx_burst = ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(1, 40);
            tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            tx_burst--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted item and stalls on a random 32-bit mask reloaded when its bits are used up.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_cnt++;
      if (frame_result_q.size() == 0) begin
        report("item with no prediction", {16'd0, out_tdata[35:20]}, 32'd0);
      end else begin
        want_res = frame_result_q.pop_front();
        if (out_tdata[0] !== want_res.clock_line)
          report("clock_line", {31'd0, out_tdata[0]}, {31'd0, want_res.clock_line});
        if (out_tdata[1] !== want_res.busy_res)
          report("busy_res", {31'd0, out_tdata[1]}, {31'd0, want_res.busy_res});
        if (out_tdata[2] !== want_res.done_res)
          report("done_res", {31'd0, out_tdata[2]}, {31'd0, want_res.done_res});
        if (out_tdata[3] !== want_res.timed_out)
          report("timed_out", {31'd0, out_tdata[3]}, {31'd0, want_res.timed_out});
        if (out_tdata[19:4] !== want_res.key_map)
          report("key_map", {16'd0, out_tdata[19:4]}, {16'd0, want_res.key_map});
        if (out_tdata[35:20] !== want_res.raw_word)
          report("raw_word", {16'd0, out_tdata[35:20]}, {16'd0, want_res.raw_word});
        if (out_tdata[39:36] !== 4'd0)
          report("padding", {28'd0, out_tdata[39:36]}, 32'd0);
      end
    end
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_slot == 0)
        rx_mask = ($urandom_range(0, 2) == 0) ? 32'hFFFFFFFF : ($urandom | $urandom);
      out_tready <= rx_mask[rx_slot];
      rx_slot = (rx_slot + 1) % 32;
    end
  end

  task automatic push_tick(input logic [1:0] func, input logic data);
    tick_item_t t;
    t.func = func;
    t.data = data;
    tick_q.push_back(t);
  endtask

  // Selector for ticks on which the sequencer is busy; mostly plain ticks.
  function automatic logic [1:0] busy_func();
    logic [1:0] f;
    f = ($urandom_range(0, 9) < 7) ? FUNC_TICK : 2'($urandom);
    if (no_calib_start && f == FUNC_CALIB) f = FUNC_UNUSED;
    return f;
  endfunction

  // One transfer as the keypad would answer it: a short low wait, then a frame whose
  // bits sit on the last tick of each clock-high half. A timeout keeps the line low.
  task automatic gen_transfer(input bit timeout, input int hp, input int sel);
    int          k;
    logic [16:0] frame;
    if (timeout) begin
      for (int i = 0; i < int'(eff_timeout()); i++) push_tick(busy_func(), 1'b0);
    end else begin
      k = $urandom_range(0, (eff_timeout() > 6) ? 5 : int'(eff_timeout()) - 1);
      repeat (k) push_tick(busy_func(), 1'b0);
      push_tick(busy_func(), 1'b1);
      case (sel)
        0:       frame = 17'd0;
        1:       frame = {17{1'b1}};
        2:       frame = ~(17'd1 << $urandom_range(0, 15));
        default: frame = 17'($urandom);
      endcase
      for (int b = 16; b >= 0; b--) begin
        for (int t = 1; t <= hp; t++) push_tick(busy_func(), (t == hp) ? frame[b] : 1'($urandom));
        for (int t = 1; t <= hp; t++) push_tick(busy_func(), 1'($urandom));
      end
    end
  endtask

  task automatic gen_read(input bit timeout, input int sel);
    push_tick(FUNC_READ, 1'($urandom));
    gen_transfer(timeout, int'(eff_half()), sel);
  endtask

  // Calibration reads from index first on; bit i of to_mask makes read i time out.
  task automatic gen_calib_reads(input int first, input logic [5:0] to_mask);
    for (int i = first; i < 6; i++) begin
      if (i > 0)
        for (int s = 0; s < int'(eff_settle()); s++) push_tick(busy_func(), 1'($urandom));
      gen_transfer(to_mask[i], int'(eff_half()), $urandom_range(0, 7));
    end
  endtask

  // Enough high-line ticks to let any read in progress run to its end.
  task automatic pad_to_idle();
    repeat (34 * int'(eff_half()) + 4) push_tick(FUNC_TICK, 1'b1);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_tvalid || frame_result_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HALF_PERIOD:   kp_half    = val[15:0];
      REG_VALID_TIMEOUT: kp_timeout = val[15:0];
      REG_SETTLE:        kp_settle  = val;
      default: ;
    endcase
  endtask

  initial begin
    int unsigned rand_items;
    int          seq_left;
    int          kind;
    int          n0;
    bit          hold_done;
    logic [1:0]  f;
    rand_items = 0;
    seq_left   = 0;
    hold_done  = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle ticks, including the unused selector, which must not start anything.
    push_tick(FUNC_TICK, 1'b0);
    push_tick(FUNC_UNUSED, 1'b1);
    push_tick(FUNC_UNUSED, 1'b0);
    push_tick(FUNC_TICK, 1'b1);

    // Read at reset timing, with starts offered while busy, then the half period is
    // lowered under it so the current half ends on the next tick.
    push_tick(FUNC_READ, 1'b0);
    repeat (3) push_tick(FUNC_TICK, 1'b0);
    push_tick(FUNC_TICK, 1'b1);
    repeat (3) begin
      push_tick(FUNC_CALIB, 1'($urandom));
      push_tick(FUNC_READ, 1'($urandom));
    end
    wait_drained();
    cfg_write(REG_HALF_PERIOD, 32'd1);
    pad_to_idle();
    wait_drained();

    // Zero registers behave as one.
    cfg_write(REG_VALID_TIMEOUT, 32'd0);
    cfg_write(REG_SETTLE, 32'd0);
    gen_read(1'b1, 0);
    gen_read(1'b0, 0);
    gen_read(1'b0, 1);
    gen_read(1'b0, 2);
    push_tick(FUNC_CALIB, 1'b0);
    gen_calib_reads(0, 6'h3F);
    wait_drained();

    // Calibration whose last read times out and falls back to the fifth result.
    cfg_write(REG_VALID_TIMEOUT, 32'd3);
    cfg_write(REG_HALF_PERIOD, 32'd2);
    push_tick(FUNC_CALIB, 1'b1);
    gen_calib_reads(0, 6'b100000);
    gen_read(1'b0, 3);
    gen_read(1'b0, 0);
    wait_drained();

    // Largest half period, cut short while in the clock-high half.
    cfg_write(REG_HALF_PERIOD, 32'd65535);
    push_tick(FUNC_READ, 1'b0);
    push_tick(FUNC_TICK, 1'b1);
    repeat (40) push_tick(busy_func(), 1'($urandom));
    wait_drained();
    cfg_write(REG_HALF_PERIOD, 32'd0);
    pad_to_idle();
    wait_drained();

    // Largest timeout, lowered during the wait so the next low tick falls back.
    cfg_write(REG_VALID_TIMEOUT, 32'd65535);
    push_tick(FUNC_READ, 1'b1);
    repeat (40) push_tick(busy_func(), 1'b0);
    wait_drained();
    cfg_write(REG_VALID_TIMEOUT, 32'd1);
    push_tick(FUNC_TICK, 1'b0);
    wait_drained();

    // Largest settle pause, lowered during the pause after the first discarded read.
    cfg_write(REG_SETTLE, 32'hFFFFFFFF);
    push_tick(FUNC_CALIB, 1'b0);
    gen_transfer(1'b1, int'(eff_half()), 0);
    repeat (40) push_tick(busy_func(), 1'($urandom));
    wait_drained();
    cfg_write(REG_SETTLE, 32'd1);
    gen_calib_reads(1, 6'($urandom));

    while (rand_items < RANDOM_ITEMS) begin
      if (seq_left == 0) begin
        wait_drained();
        cfg_write(REG_HALF_PERIOD, ($urandom_range(0, 5) == 0) ? 32'd4 : $urandom_range(0, 3));
        cfg_write(REG_VALID_TIMEOUT, $urandom_range(0, 10));
        cfg_write(REG_SETTLE, $urandom_range(0, 6));
        seq_left = $urandom_range(3, 8);
        if (!hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end
      seq_left--;
      n0   = tick_q.size();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4: gen_read($urandom_range(0, 4) == 0, $urandom_range(0, 7));
        5, 6: begin
          push_tick(FUNC_CALIB, 1'($urandom));
          gen_calib_reads(0, ($urandom_range(0, 5) == 0) ? 6'h3F : 6'($urandom & $urandom));
        end
        7: begin
          // Random ticks; only reads may start here so the padding can resync.
          repeat ($urandom_range(5, 20)) begin
            f = 2'($urandom);
            if (f == FUNC_CALIB) f = FUNC_UNUSED;
            push_tick(f, 1'($urandom));
          end
          no_calib_start = 1'b1;
          pad_to_idle();
          no_calib_start = 1'b0;
        end
        8: begin
          // Frame sent with the wrong half period.
          no_calib_start = 1'b1;
          push_tick(FUNC_READ, 1'($urandom));
          gen_transfer(1'b0, int'(eff_half()) + 1, $urandom_range(0, 7));
          pad_to_idle();
          no_calib_start = 1'b0;
        end
        default: begin
          repeat ($urandom_range(1, 5))
            push_tick(($urandom_range(0, 1) == 0) ? FUNC_TICK : FUNC_UNUSED, 1'($urandom));
        end
      endcase
      rand_items += tick_q.size() - n0;
    end

    wait_drained();
    if (frame_result_q.size() != 0)
      report("predictions left over", frame_result_q.size(), 32'd0);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
